@@ rtl/core/art_pkg.sv @@
// ----------------------------------------------------------------------------
// art_pkg: shared types and constants of the acknowledgement tracker
// Slot count, field widths, command and result codes, and the slot record.
// ----------------------------------------------------------------------------
package art_pkg;

    localparam int SLOTS       = 8;
    localparam int MAX_RESULTS = 8;

    localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(MAX_RESULTS + 1);

    localparam int ID_W    = 16;
    localparam int RETRY_W = 4;
    localparam int AGE_W   = 16;
    localparam int CMD_W   = 2;
    localparam int KIND_W  = 3;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'd1;

    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST   = 4'd3;
    localparam logic [AGE_W-1:0]   TIMEOUT_TICKS_RST = 16'd250;

    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_RECORD  = 2'd0,
        CMD_CONFIRM = 2'd1,
        CMD_REPLY   = 2'd2,
        CMD_TICK    = 2'd3
    } art_cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_DONE     = 3'd0,
        KIND_FOUND    = 3'd1,
        KIND_NOTFOUND = 3'd2,
        KIND_FULL     = 3'd3,
        KIND_RETX     = 3'd4,
        KIND_GIVEUP   = 3'd5
    } art_kind_t;

    typedef struct packed {
        logic               valid;
        logic [ID_W-1:0]    id;
        logic [RETRY_W-1:0] retries;
        logic [AGE_W-1:0]   age;
        logic               confirmed;
    } art_slot_t;

    // One response handed from the sequencer to the output register.
    typedef struct packed {
        logic            valid;
        art_kind_t       kind;
        logic [ID_W-1:0] id;
        logic            last;
    } art_push_t;

endpackage

@@ rtl/core/art_if.sv @@
// ----------------------------------------------------------------------------
// art_if: request and response channels of the acknowledgement tracker
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface art_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] msg_id;
    logic        reply_ok;

    modport source (output valid, output cmd, output msg_id, output reply_ok,
                    input ready);
    modport sink   (input valid, input cmd, input msg_id, input reply_ok,
                    output ready);
endinterface

interface art_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_kind;
    logic [15:0] result_id;
    logic        last;

    modport source (output valid, output result_kind, output result_id,
                    output last, input ready);
    modport sink   (input valid, input result_kind, input result_id,
                    input last, output ready);
endinterface

@@ rtl/core/art_table.sv @@
// ----------------------------------------------------------------------------
// art_table: slot storage of the acknowledgement tracker
// One read and one write port at the slot the sequencer is visiting.
// ----------------------------------------------------------------------------
module art_table (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [art_pkg::SLOT_IW-1:0] idx,
    input  logic                       wr_en,
    input  art_pkg::art_slot_t         wr_data,
    output art_pkg::art_slot_t         rd_data
);
    import art_pkg::*;

    logic [SLOTS-1:0]   valid_reg;
    logic [ID_W-1:0]    id_reg      [SLOTS];
    logic [RETRY_W-1:0] retries_reg [SLOTS];
    logic [AGE_W-1:0]   age_reg     [SLOTS];
    logic               conf_reg    [SLOTS];

    // Valid bits clear at reset; the rest is only read behind a valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[idx] <= wr_data.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            id_reg[idx]      <= wr_data.id;
            retries_reg[idx] <= wr_data.retries;
            age_reg[idx]     <= wr_data.age;
            conf_reg[idx]    <= wr_data.confirmed;
        end
    end

    always_comb
    begin
        rd_data.valid     = valid_reg[idx];
        rd_data.id        = id_reg[idx];
        rd_data.retries   = retries_reg[idx];
        rd_data.age       = age_reg[idx];
        rd_data.confirmed = conf_reg[idx];
    end

endmodule

@@ rtl/core/art_seq.sv @@
// ----------------------------------------------------------------------------
// art_seq: slot walker of the acknowledgement tracker
// Visits one slot per cycle with a shared compare/age unit, unless a tick stalls, and issues responses.
// ----------------------------------------------------------------------------
module art_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  art_pkg::art_cmd_t             cmd,
    input  logic [art_pkg::ID_W-1:0]      msg_id,
    input  logic                          reply_ok,
    input  logic [art_pkg::RETRY_W-1:0]   retry_limit,
    input  logic [art_pkg::AGE_W-1:0]     timeout_ticks,
    input  logic                          out_free,
    output logic                          idle,
    output logic [art_pkg::SLOT_IW-1:0]   idx,
    input  art_pkg::art_slot_t            rd_data,
    output logic                          wr_en,
    output art_pkg::art_slot_t            wr_data,
    output art_pkg::art_push_t            push
);
    import art_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    state_t               state_reg,      state_next;
    logic [SLOT_IW-1:0]   idx_reg,        idx_next;
    art_cmd_t             cmd_reg,        cmd_next;
    logic [ID_W-1:0]      id_reg,         id_next;
    logic                 ok_reg,         ok_next;
    logic                 found_reg,      found_next;
    logic                 walk_on_reg,    walk_on_next;
    logic [CNT_W-1:0]     n_reg,          n_next;
    logic                 pend_valid_reg, pend_valid_next;
    art_kind_t            pend_kind_reg,  pend_kind_next;
    logic [ID_W-1:0]      pend_id_reg,    pend_id_next;

    logic             last_slot;
    logic             match;
    logic [AGE_W-1:0] aged;
    logic             timed_out;
    logic             walk_act;
    logic             event_hit;
    logic             stall;

    // Shared unit: id compare, saturating age step and timeout compare.
    assign last_slot = (idx_reg == SLOT_IW'(SLOTS - 1));
    assign match     = rd_data.valid && (rd_data.id == id_reg);
    assign aged      = (rd_data.age == AGE_MAX) ? rd_data.age : rd_data.age + 1'b1;
    assign timed_out = (aged > timeout_ticks);
    assign walk_act  = walk_on_reg && (n_reg != CNT_W'(MAX_RESULTS));
    assign event_hit = rd_data.valid && walk_act && timed_out
                       && ((rd_data.retries == '0) || !rd_data.confirmed);
    assign stall     = event_hit && pend_valid_reg && !out_free;

    assign idle = (state_reg == ST_IDLE);
    assign idx  = idx_reg;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        ok_next         = ok_reg;
        found_next      = found_reg;
        walk_on_next    = walk_on_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_id_next    = pend_id_reg;
        wr_en           = 1'b0;
        wr_data         = rd_data;
        push            = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next        = cmd;
                    id_next         = msg_id;
                    ok_next         = reply_ok;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    walk_on_next    = 1'b1;
                    n_next          = '0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_WALK;
                end
            end

            ST_WALK:
            begin
                unique case (cmd_reg)
                    CMD_RECORD:
                    begin
                        if (!rd_data.valid)
                        begin
                            wr_en             = 1'b1;
                            wr_data.valid     = 1'b1;
                            wr_data.id        = id_reg;
                            wr_data.retries   = retry_limit;
                            wr_data.age       = '0;
                            wr_data.confirmed = 1'b0;
                            pend_valid_next   = 1'b1;
                            pend_kind_next    = KIND_DONE;
                            pend_id_next      = id_reg;
                            state_next        = ST_FINISH;
                        end
                        else if (last_slot)
                        begin
                            pend_valid_next = 1'b1;
                            pend_kind_next  = KIND_FULL;
                            pend_id_next    = id_reg;
                            state_next      = ST_FINISH;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end

                    CMD_CONFIRM, CMD_REPLY:
                    begin
                        if (cmd_reg == CMD_REPLY && !ok_reg)
                        begin
                            // Failed reply: drop every matching slot.
                            if (match)
                            begin
                                wr_en         = 1'b1;
                                wr_data.valid = 1'b0;
                            end
                            if (last_slot)
                            begin
                                pend_valid_next = 1'b1;
                                pend_kind_next  = (found_reg || match) ? KIND_FOUND
                                                                       : KIND_NOTFOUND;
                                pend_id_next    = id_reg;
                                state_next      = ST_FINISH;
                            end
                            else
                            begin
                                found_next = found_reg || match;
                                idx_next   = idx_reg + 1'b1;
                            end
                        end
                        else if (match)
                        begin
                            // First hit confirms, second hit frees.
                            wr_en = 1'b1;
                            if (!rd_data.confirmed)
                            begin
                                wr_data.confirmed = 1'b1;
                            end
                            else
                            begin
                                wr_data.valid = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_kind_next  = KIND_FOUND;
                            pend_id_next    = id_reg;
                            state_next      = ST_FINISH;
                        end
                        else if (last_slot)
                        begin
                            pend_valid_next = 1'b1;
                            pend_kind_next  = KIND_NOTFOUND;
                            pend_id_next    = id_reg;
                            state_next      = ST_FINISH;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end

                    CMD_TICK:
                    begin
                        if (!stall)
                        begin
                            if (rd_data.valid)
                            begin
                                wr_en       = 1'b1;
                                wr_data.age = aged;
                            end
                            if (event_hit)
                            begin
                                // Flush the held response; it is not the final one.
                                if (pend_valid_reg)
                                begin
                                    push.valid = 1'b1;
                                    push.kind  = pend_kind_reg;
                                    push.id    = pend_id_reg;
                                    push.last  = 1'b0;
                                end
                                pend_valid_next = 1'b1;
                                pend_id_next    = rd_data.id;
                                n_next          = n_reg + 1'b1;
                                if (rd_data.retries != '0)
                                begin
                                    wr_data.retries = rd_data.retries - 1'b1;
                                    wr_data.age     = '0;
                                    pend_kind_next  = KIND_RETX;
                                end
                                else
                                begin
                                    wr_data.valid  = 1'b0;
                                    pend_kind_next = KIND_GIVEUP;
                                    walk_on_next   = 1'b0;
                                end
                            end
                            if (last_slot)
                            begin
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                idx_next = idx_reg + 1'b1;
                            end
                        end
                    end

                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    push.valid = 1'b1;
                    push.kind  = pend_valid_reg ? pend_kind_reg : KIND_DONE;
                    push.id    = pend_valid_reg ? pend_id_reg : id_reg;
                    push.last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            cmd_reg        <= CMD_RECORD;
            id_reg         <= '0;
            ok_reg         <= 1'b0;
            found_reg      <= 1'b0;
            walk_on_reg    <= 1'b0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            pend_kind_reg  <= KIND_DONE;
            pend_id_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cmd_reg        <= cmd_next;
            id_reg         <= id_next;
            ok_reg         <= ok_next;
            found_reg      <= found_next;
            walk_on_reg    <= walk_on_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            pend_kind_reg  <= pend_kind_next;
            pend_id_reg    <= pend_id_next;
        end
    end

endmodule

@@ rtl/core/ack_retransmit_tracker.sv @@
// ----------------------------------------------------------------------------
// ack_retransmit_tracker: table of sent messages awaiting acknowledgement
// Records, confirms and ages messages; emits retransmit and give-up responses.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request (cmd, msg_id, reply_ok); rsp carries responses
//   (result_kind, result_id, last). Both are valid/ready channels; a transfer
//   happens when valid and ready are high at a rising edge of clk.
//   Every request yields one or more responses; the final one has last set.
//   req.ready is high only while the walker is idle. A request visits the
//   slots one per cycle through a shared compare/age unit, unless a tick
//   stalls on the output register: a record stops at the first free slot,
//   a confirm or a good reply at the first hit, and a failed reply and a
//   tick visit all SLOTS slots. A new request waits until the walker is
//   idle again after the final response.
//   rsp has a one-deep output register; while it holds an untaken response
//   the walker stalls on the slot that wants to report, so nothing is lost.
//   Tick responses are held one step back so that last marks the true end.
//   Registers (cfg_wr_en/cfg_index/cfg_data), index 0 retry_limit, index 1
//   timeout_ticks, must be written only while idle; the block does not check.
//   Reset (rst_n low, asynchronous) frees all slots, restores retry_limit 3
//   and timeout_ticks 250, and drops any pending response.
// ----------------------------------------------------------------------------
module ack_retransmit_tracker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [art_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [art_pkg::CFG_DATA_W-1:0]    cfg_data,
    art_req_if.sink                           req,
    art_rsp_if.source                         rsp
);
    import art_pkg::*;

    logic [RETRY_W-1:0] retry_limit_reg;
    logic [AGE_W-1:0]   timeout_ticks_reg;

    logic               out_valid_reg;
    logic [KIND_W-1:0]  out_kind_reg;
    logic [ID_W-1:0]    out_id_reg;
    logic               out_last_reg;

    logic               idle;
    logic               start;
    logic               out_free;
    logic [SLOT_IW-1:0] idx;
    logic               wr_en;
    art_slot_t          wr_data;
    art_slot_t          rd_data;
    art_push_t          push;

    // Configuration registers; a write to a register hits at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg   <= RETRY_LIMIT_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_RETRY_LIMIT:   retry_limit_reg   <= cfg_data[RETRY_W-1:0];
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[AGE_W-1:0];
                default:           ;
            endcase
        end
    end

    // Accept a request only while the walker is idle.
    assign req.ready = idle;
    assign start     = req.valid && idle;

    art_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .idx     (idx),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    art_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .cmd           (art_cmd_t'(req.cmd)),
        .msg_id        (req.msg_id),
        .reply_ok      (req.reply_ok),
        .retry_limit   (retry_limit_reg),
        .timeout_ticks (timeout_ticks_reg),
        .out_free      (out_free),
        .idle          (idle),
        .idx           (idx),
        .rd_data       (rd_data),
        .wr_en         (wr_en),
        .wr_data       (wr_data),
        .push          (push)
    );

    // Output register: load a new response when empty or being drained.
    assign out_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            out_kind_reg <= push.kind;
            out_id_reg   <= push.id;
            out_last_reg <= push.last;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.result_kind = out_kind_reg;
    assign rsp.result_id   = out_id_reg;
    assign rsp.last        = out_last_reg;

    // Never load a response over one that is still waiting.
    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> out_free)
        else $error("response loaded into an occupied output register");

    // An accepted request keeps the walker busy in the next cycle.
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !req.ready)
        else $error("walker idle right after accepting a request");

    // No response leaves the walker while it is idle.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        idle |-> !push.valid)
        else $error("response issued while idle");

    // The final response returns the walker to idle.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && push.last) |=> req.ready)
        else $error("walker still busy after the final response");

endmodule
